/* rtl/icmp_quoted_udp_hop_parser_defines.svh */
// Assertion macros shared by the checking code of the hop parser.
`ifndef ICMP_QUOTED_UDP_HOP_PARSER_DEFINES_SVH
`define ICMP_QUOTED_UDP_HOP_PARSER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define IQUHP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hop parser check failed");

// Next-cycle implication, active through reset as well.
`define IQUHP_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hop parser check failed");

`endif

/* rtl/iquhp_pkg.sv */
`default_nettype none

package iquhp_pkg;

    // Packet geometry.
    localparam int MAX_PACKET_BYTES = 1024;
    localparam int POS_W            = 11;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam int ICMP_HDR_BYTES   = 8;
    localparam int MIN_IP_BYTES     = 20;
    localparam int PORT_BYTES       = 4;
    localparam int INNER_PROTO_OFS  = 9;
    localparam int DPORT_OFS        = 2;
    localparam int SRC_FIRST        = 12;
    localparam int SRC_LAST         = 15;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Configuration registers.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PORT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 1'b1;
    localparam logic [15:0] BASE_PORT_RESET  = 16'd60000;
    localparam logic [16:0] SLOT_LIMIT_RESET = 17'd500;

    // Output word layout.
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [2:0] {
        VERDICT_RECORDED    = 3'd0,
        VERDICT_ICMP_SHORT  = 3'd1,
        VERDICT_INNER_SHORT = 3'd2,
        VERDICT_PORTS_SHORT = 3'd3,
        VERDICT_NOT_UDP     = 3'd4,
        VERDICT_BELOW_BASE  = 3'd5,
        VERDICT_SLOT_RANGE  = 3'd6
    } t_verdict;

    // Header fields as they stand once the current byte is taken into account.
    typedef struct packed {
        logic [POS_W-1:0] byte_count;
        logic [3:0]       outer_ihl;
        logic [3:0]       inner_ihl;
        logic [7:0]       inner_protocol;
        logic [15:0]      dest_port;
        logic [31:0]      source_addr;
    } t_pkt_view;

    typedef struct packed {
        logic [31:0] router_address;
        logic [15:0] hop_slot;
        t_verdict    verdict;
    } t_result;

endpackage

`default_nettype wire

/* rtl/iquhp_capture.sv */
`default_nettype none

module iquhp_capture (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_advance,
    input  wire logic [7:0]            i_data,
    input  wire logic                  i_last,
    output iquhp_pkg::t_pkt_view       o_view
);
    import iquhp_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [3:0]       r_outer_ihl;
    logic [31:0]      r_src_addr;
    logic [3:0]       r_inner_ihl;
    logic [7:0]       r_inner_proto;
    logic [15:0]      r_dest_port;

    logic [POS_W-1:0] n_pos;
    logic [3:0]       n_outer_ihl;
    logic [31:0]      n_src_addr;
    logic [3:0]       n_inner_ihl;
    logic [7:0]       n_inner_proto;
    logic [15:0]      n_dest_port;

    logic [6:0]       inner_at;
    logic [7:0]       port_at;
    logic [POS_W-1:0] byte_count;

    // Offsets of the quoted header and the destination port inside this packet.
    always_comb begin
        inner_at = {1'b0, r_outer_ihl, 2'b00} + 7'(ICMP_HDR_BYTES);
        port_at  = {1'b0, inner_at} + {2'b00, r_inner_ihl, 2'b00} + 8'(DPORT_OFS);
    end

    // Field capture for the word in the input register.
    always_comb begin
        n_outer_ihl   = r_outer_ihl;
        n_src_addr    = r_src_addr;
        n_inner_ihl   = r_inner_ihl;
        n_inner_proto = r_inner_proto;
        n_dest_port   = r_dest_port;
        if (r_pos == '0) begin
            n_outer_ihl = i_data[3:0];
        end
        if (r_pos >= POS_W'(SRC_FIRST) && r_pos <= POS_W'(SRC_LAST)) begin
            n_src_addr = {r_src_addr[23:0], i_data};
        end
        if (r_pos == POS_W'(inner_at)) begin
            n_inner_ihl = i_data[3:0];
        end
        if (r_pos == POS_W'(inner_at) + POS_W'(INNER_PROTO_OFS)) begin
            n_inner_proto = i_data;
        end
        if (r_pos == POS_W'(port_at)) begin
            n_dest_port = {i_data, r_dest_port[7:0]};
        end
        if (r_pos == POS_W'(port_at) + POS_W'(1)) begin
            n_dest_port = {r_dest_port[15:8], i_data};
        end
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);
    end

    // Length seen so far, capped at the largest packet handled.
    always_comb begin
        if (r_pos >= POS_W'(MAX_PACKET_BYTES - 1)) begin
            byte_count = POS_W'(MAX_PACKET_BYTES);
        end else begin
            byte_count = r_pos + POS_W'(1);
        end
    end

    assign o_view = '{
        byte_count:     byte_count,
        outer_ihl:      n_outer_ihl,
        inner_ihl:      n_inner_ihl,
        inner_protocol: n_inner_proto,
        dest_port:      n_dest_port,
        source_addr:    n_src_addr
    };

    // Per-packet state; the final byte returns everything to the start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_outer_ihl   <= '0;
            r_src_addr    <= '0;
            r_inner_ihl   <= '0;
            r_inner_proto <= '0;
            r_dest_port   <= '0;
        end else if (i_advance) begin
            if (i_last) begin
                r_pos         <= '0;
                r_outer_ihl   <= '0;
                r_src_addr    <= '0;
                r_inner_ihl   <= '0;
                r_inner_proto <= '0;
                r_dest_port   <= '0;
            end else begin
                r_pos         <= n_pos;
                r_outer_ihl   <= n_outer_ihl;
                r_src_addr    <= n_src_addr;
                r_inner_ihl   <= n_inner_ihl;
                r_inner_proto <= n_inner_proto;
                r_dest_port   <= n_dest_port;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/iquhp_check.sv */
`default_nettype none

module iquhp_check (
    input  wire iquhp_pkg::t_pkt_view  i_view,
    input  wire logic [15:0]           i_base_port,
    input  wire logic [16:0]           i_slot_limit,
    output iquhp_pkg::t_result         o_result
);
    import iquhp_pkg::*;

    logic [POS_W-1:0] outer_len;
    logic [POS_W-1:0] need_icmp;
    logic [POS_W-1:0] need_inner;
    logic [POS_W-1:0] need_ports;
    logic [15:0]      slot;

    // Minimum lengths for each layer, measured from the start of the packet.
    always_comb begin
        outer_len  = POS_W'({i_view.outer_ihl, 2'b00});
        need_icmp  = outer_len + POS_W'(ICMP_HDR_BYTES);
        need_inner = need_icmp + POS_W'(MIN_IP_BYTES);
        need_ports = need_icmp + POS_W'({i_view.inner_ihl, 2'b00}) + POS_W'(PORT_BYTES);
        slot       = i_view.dest_port - i_base_port;
    end

    // Verdict, first failing check wins.
    always_comb begin
        o_result = '{router_address: '0, hop_slot: '0, verdict: VERDICT_RECORDED};
        priority if (i_view.byte_count < need_icmp) begin
            o_result.verdict = VERDICT_ICMP_SHORT;
        end else if (i_view.byte_count < need_inner) begin
            o_result.verdict = VERDICT_INNER_SHORT;
        end else if (i_view.byte_count < need_ports) begin
            o_result.verdict = VERDICT_PORTS_SHORT;
        end else if (i_view.inner_protocol != PROTO_UDP) begin
            o_result.verdict = VERDICT_NOT_UDP;
        end else if (i_view.dest_port < i_base_port) begin
            o_result.verdict = VERDICT_BELOW_BASE;
        end else if ({1'b0, slot} >= i_slot_limit) begin
            o_result.verdict = VERDICT_SLOT_RANGE;
        end else begin
            o_result.hop_slot       = slot;
            o_result.router_address = i_view.source_addr;
        end
    end

endmodule

`default_nettype wire

/* rtl/icmp_quoted_udp_hop_parser.sv */
// The final byte is taken into the input register, and its result word is then loaded into
// the result register, as long as the result register is free at that point.
// Throughput: one byte per clock, set by the single pass of field capture and checks
// between the input register and the result register; a final byte waits only while
// an earlier result word is still held.
// Reset (synchronous, active low) empties both registers, clears the packet state and
// restores base port 60000 and slot limit 500.
`default_nettype none

module icmp_quoted_udp_hop_parser (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Slave side: tdata = data_byte; tlast = last_byte.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,
    input  wire logic                                s_axis_tlast,
    // Master side: tdata = verdict [2:0], hop_slot [18:3], router_address [50:19], zeros.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [iquhp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // Configuration write port.
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [iquhp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [iquhp_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data
);
    import iquhp_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out_result;
    logic [15:0] r_base_port;
    logic [16:0] r_slot_limit;

    logic        advance;
    t_pkt_view   view;
    t_result     n_result;

    // A byte moves on unless it closes a packet while the result register is blocked.
    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_port  <= BASE_PORT_RESET;
            r_slot_limit <= SLOT_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BASE_PORT:  r_base_port  <= i_cfg_wr_data[15:0];
                CFG_SLOT_LIMIT: r_slot_limit <= i_cfg_wr_data;
                default:        r_base_port  <= r_base_port;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    iquhp_capture u_capture (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_data    (r_in_data),
        .i_last    (r_in_last),
        .o_view    (view)
    );

    iquhp_check u_check (
        .i_view       (view),
        .i_base_port  (r_base_port),
        .i_slot_limit (r_slot_limit),
        .o_result     (n_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_result);

endmodule

`default_nettype wire

/* rtl/iquhp_checker.sv */
`default_nettype none
`include "icmp_quoted_udp_hop_parser_defines.svh"

module iquhp_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [iquhp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import iquhp_pkg::*;

    // A held result word must not change until it is taken.
    `IQUHP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n && m_axis_tvalid && !m_axis_tready, !i_rst_n || (m_axis_tvalid && $stable(m_axis_tdata)))

    // Nothing is offered in the cycle after reset.
    `IQUHP_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)

    // Only the seven defined verdict codes appear.
    `IQUHP_ASSERT_IMPLIES(a_verdict_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[2:0] != 3'd7)

    // A rejected packet carries neither slot nor router address.
    `IQUHP_ASSERT_IMPLIES(a_reject_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[2:0] != VERDICT_RECORDED), m_axis_tdata[OUT_TDATA_W-1:3] == '0)

    // With the sink taking words the input side never stalls.
    `IQUHP_ASSERT_IMPLIES(a_no_stall, i_clk, i_rst_n, m_axis_tready, s_axis_tready)

endmodule

bind icmp_quoted_udp_hop_parser iquhp_checker u_iquhp_checker (.*);

`default_nettype wire
